// ===== rtl/mips_subset_single_cycle_core_macros.svh =====
// Assertion macros shared by the core RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MSSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MSSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MSSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`define MSSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/mssc_pkg.sv =====
// Package for the MIPS subset core: opcodes, function codes, status codes
// and the request / response payload structs. No dependencies.
`default_nettype none

package mssc_pkg;

   localparam logic [5:0] OP_RTYPE = 6'b000000;
   localparam logic [5:0] OP_J     = 6'b000010;
   localparam logic [5:0] OP_ADDIU = 6'b001001;
   localparam logic [5:0] OP_BEQ   = 6'b000100;
   localparam logic [5:0] OP_LW    = 6'b100011;
   localparam logic [5:0] OP_SW    = 6'b101011;

   localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

   localparam logic [2:0] FN_ADDU = 3'b001;
   localparam logic [2:0] FN_SUBU = 3'b011;
   localparam logic [2:0] FN_AND  = 3'b100;
   localparam logic [2:0] FN_OR   = 3'b101;
   localparam logic [2:0] FN_NOR  = 3'b111;

   localparam logic [1:0] STATUS_EXEC    = 2'd0;
   localparam logic [1:0] STATUS_HALT    = 2'd1;
   localparam logic [1:0] STATUS_ILLEGAL = 2'd2;
   localparam logic [1:0] STATUS_PRELOAD = 2'd3;

   localparam logic REQ_EXEC    = 1'b0;
   localparam logic REQ_PRELOAD = 1'b1;

   localparam int unsigned REG_COUNT = 32;

   typedef struct packed {
      logic        req_type;
      logic [31:0] instruction;
      logic [9:0]  load_index;
      logic [31:0] load_value;
   } req_item_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [1:0]  status;
      logic        reg_write_en;
      logic [4:0]  reg_write_index;
      logic [31:0] reg_write_value;
      logic        mem_write_en;
      logic [9:0]  mem_access_index;
      logic [31:0] mem_write_value;
      logic        branch_taken;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/mssc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read returns the old word on a same-cycle write. No dependencies.
`default_nettype none

module mssc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mips_subset_single_cycle_core.sv =====
// Top level of the MIPS subset core: register file, data memory, pc and
// output queue. Depends on mssc_pkg, mssc_ram and the assertion macro header.
//
// Each request either executes one fetched instruction (addu, subu, and, or,
// nor, addiu, lw, sw, beq, j, all-ones halt) or preloads one data memory word,
// and produces exactly one response. The core takes one request per clock
// while req_ready is high: the request is registered, executed in the next
// cycle (operands come from the register file read issued at acceptance,
// with bypass from the two older instructions), and the result passes a
// writeback register, where a load picks up its data memory word, into a
// four-entry response queue. req_ready drops only while four requests are
// in flight or queued, and after reset while a clearing pass zeroes the data
// memory and the register file. DATA_WORDS must be a power of two; memory
// indexes are the low bits of the effective address.
`default_nettype none
`include "mips_subset_single_cycle_core_macros.svh"

module mips_subset_single_cycle_core #(
   parameter int DATA_WORDS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mssc_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mssc_pkg::rsp_item_type rsp_item
);

   import mssc_pkg::*;

   localparam int DM_AW      = $clog2(DATA_WORDS);
   localparam int CLR_WORDS  = (DATA_WORDS > REG_COUNT) ? DATA_WORDS : REG_COUNT;
   localparam int CLR_W      = $clog2(CLR_WORDS);
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_AW     = $clog2(OUT_DEPTH);
   localparam int CNT_W      = $clog2(OUT_DEPTH + 3);

   // clearing pass
   logic             clr_busy_ff;
   logic [CLR_W-1:0] clr_cnt_ff;

   // execute stage
   logic         req_accept;
   logic         ex_vld_ff;
   req_item_type ex_item_ff;
   logic         fa_rs_hit_ff;
   logic         fa_rt_hit_ff;
   logic [31:0]  fa_val_ff;
   logic [31:0]  rf_a_rdata;
   logic [31:0]  rf_b_rdata;

   logic [31:0] pc_ff, pc_in;
   logic        halted_ff, halted_in;

   logic [5:0]       ex_op;
   logic [4:0]       ex_rs, ex_rt, ex_rd;
   logic [2:0]       ex_fn;
   logic [31:0]      op_a, op_b;
   logic [31:0]      simm, seq_pc, ea, alu_r;
   logic             alu_ok;
   logic [DM_AW-1:0] ea_idx;
   rsp_item_type     ex_res;
   logic             ex_load;
   logic             ex_dm_we;
   logic [DM_AW-1:0] ex_dm_addr;
   logic [31:0]      ex_dm_data;

   // writeback stage
   logic         wb_vld_ff;
   rsp_item_type wb_res_ff;
   logic         wb_load_ff;
   logic [31:0]  dm_rdata;
   logic [31:0]  wb_value;
   logic         wb_writes;
   rsp_item_type wb_final;

   // RAM ports
   logic             rf_we;
   logic [4:0]       rf_waddr;
   logic [31:0]      rf_wdata;
   logic             dm_we;
   logic [DM_AW-1:0] dm_waddr;
   logic [31:0]      dm_wdata;

   // response queue
   rsp_item_type      out_q_ff [OUT_DEPTH];
   logic [OUT_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  inflight;
   logic              deq;

   assign inflight   = CNT_W'(ex_vld_ff) + CNT_W'(wb_vld_ff) + cnt_ff;
   assign req_ready  = !clr_busy_ff && (inflight < CNT_W'(OUT_DEPTH));
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CLR_W'(CLR_WORDS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // register file: two copies, one per read port, written together
   assign wb_writes = wb_vld_ff && wb_res_ff.reg_write_en;
   assign wb_value  = wb_load_ff ? dm_rdata : wb_res_ff.reg_write_value;
   assign rf_we     = clr_busy_ff || wb_writes;
   assign rf_waddr  = clr_busy_ff ? clr_cnt_ff[4:0] : wb_res_ff.reg_write_index;
   assign rf_wdata  = clr_busy_ff ? 32'd0 : wb_value;

   mssc_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) rf_a_ram (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (req_item.instruction[25:21]),
      .rd_data (rf_a_rdata)
   );

   mssc_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) rf_b_ram (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (req_item.instruction[20:16]),
      .rd_data (rf_b_rdata)
   );

   // entry register; the writeback happening at this edge is captured as bypass
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff    <= 1'b0;
         fa_rs_hit_ff <= 1'b0;
         fa_rt_hit_ff <= 1'b0;
      end else begin
         ex_vld_ff    <= req_accept;
         fa_rs_hit_ff <= wb_writes &&
                         (wb_res_ff.reg_write_index == req_item.instruction[25:21]);
         fa_rt_hit_ff <= wb_writes &&
                         (wb_res_ff.reg_write_index == req_item.instruction[20:16]);
      end
      ex_item_ff <= req_item;
      fa_val_ff  <= wb_value;
   end

   assign ex_op = ex_item_ff.instruction[31:26];
   assign ex_rs = ex_item_ff.instruction[25:21];
   assign ex_rt = ex_item_ff.instruction[20:16];
   assign ex_rd = ex_item_ff.instruction[15:11];
   assign ex_fn = ex_item_ff.instruction[2:0];

   // operand bypass: writeback stage first, then the write seen at entry
   always_comb begin
      if (wb_writes && (wb_res_ff.reg_write_index == ex_rs)) begin
         op_a = wb_value;
      end else if (fa_rs_hit_ff) begin
         op_a = fa_val_ff;
      end else begin
         op_a = rf_a_rdata;
      end
      if (wb_writes && (wb_res_ff.reg_write_index == ex_rt)) begin
         op_b = wb_value;
      end else if (fa_rt_hit_ff) begin
         op_b = fa_val_ff;
      end else begin
         op_b = rf_b_rdata;
      end
   end

   assign simm   = {{16{ex_item_ff.instruction[15]}}, ex_item_ff.instruction[15:0]};
   assign seq_pc = pc_ff + 32'd4;
   assign ea     = op_a + simm;
   assign ea_idx = ea[DM_AW-1:0];

   always_comb begin
      alu_ok = 1'b1;
      unique case (ex_fn)
         FN_ADDU: alu_r = op_a + op_b;
         FN_SUBU: alu_r = op_a - op_b;
         FN_AND:  alu_r = op_a & op_b;
         FN_OR:   alu_r = op_a | op_b;
         FN_NOR:  alu_r = ~(op_a | op_b);
         default: begin
            alu_r  = 32'd0;
            alu_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      ex_res         = '0;
      ex_res.next_pc = pc_ff;
      ex_res.status  = STATUS_EXEC;
      ex_load        = 1'b0;
      ex_dm_we       = 1'b0;
      ex_dm_addr     = ea_idx;
      ex_dm_data     = op_b;
      halted_in      = halted_ff;
      if (ex_vld_ff) begin
         if (ex_item_ff.req_type == REQ_PRELOAD) begin
            ex_res.status = STATUS_PRELOAD;
            ex_dm_we      = 1'b1;
            ex_dm_addr    = DM_AW'(ex_item_ff.load_index);
            ex_dm_data    = ex_item_ff.load_value;
         end else if (halted_ff) begin
            ex_res.status = STATUS_HALT;
         end else if (ex_item_ff.instruction == HALT_WORD) begin
            ex_res.status = STATUS_HALT;
            halted_in     = 1'b1;
         end else begin
            unique case (ex_op)
               OP_RTYPE: begin
                  if (alu_ok) begin
                     ex_res.reg_write_en    = 1'b1;
                     ex_res.reg_write_index = ex_rd;
                     ex_res.reg_write_value = alu_r;
                     ex_res.next_pc         = seq_pc;
                  end else begin
                     ex_res.status = STATUS_ILLEGAL;
                  end
               end
               OP_ADDIU: begin
                  ex_res.reg_write_en    = 1'b1;
                  ex_res.reg_write_index = ex_rt;
                  ex_res.reg_write_value = ea;
                  ex_res.next_pc         = seq_pc;
               end
               OP_LW: begin
                  // value is filled in at writeback from the data memory
                  ex_load                 = 1'b1;
                  ex_res.reg_write_en     = 1'b1;
                  ex_res.reg_write_index  = ex_rt;
                  ex_res.mem_access_index = 10'(ea_idx);
                  ex_res.next_pc          = seq_pc;
               end
               OP_SW: begin
                  ex_dm_we                = 1'b1;
                  ex_res.mem_write_en     = 1'b1;
                  ex_res.mem_access_index = 10'(ea_idx);
                  ex_res.mem_write_value  = op_b;
                  ex_res.next_pc          = seq_pc;
               end
               OP_BEQ: begin
                  if (op_a == op_b) begin
                     ex_res.next_pc      = seq_pc + {simm[29:0], 2'b00};
                     ex_res.branch_taken = 1'b1;
                  end else begin
                     ex_res.next_pc = seq_pc;
                  end
               end
               OP_J: begin
                  ex_res.next_pc      = {seq_pc[31:28], ex_item_ff.instruction[25:0], 2'b00};
                  ex_res.branch_taken = 1'b1;
               end
               default: ex_res.status = STATUS_ILLEGAL;
            endcase
         end
      end
      pc_in = ex_vld_ff ? ex_res.next_pc : pc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         halted_ff <= 1'b0;
      end else begin
         pc_ff     <= pc_in;
         halted_ff <= halted_in;
      end
   end

   // data memory
   assign dm_we    = clr_busy_ff || ex_dm_we;
   assign dm_waddr = clr_busy_ff ? clr_cnt_ff[DM_AW-1:0] : ex_dm_addr;
   assign dm_wdata = clr_busy_ff ? 32'd0 : ex_dm_data;

   mssc_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) dm_ram (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_addr (ea_idx),
      .rd_data (dm_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_vld_ff <= 1'b0;
      end else begin
         wb_vld_ff <= ex_vld_ff;
      end
      wb_res_ff  <= ex_res;
      wb_load_ff <= ex_load;
   end

   always_comb begin
      wb_final                 = wb_res_ff;
      wb_final.reg_write_value = wb_value;
   end

   // response queue; entry is reserved at request transfer, so it never overflows
   assign deq       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_item  = out_q_ff[rd_ptr_ff];
   assign cnt_in    = cnt_ff + CNT_W'(wb_vld_ff) - CNT_W'(deq);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (wb_vld_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (deq) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
      if (wb_vld_ff) begin
         out_q_ff[wr_ptr_ff] <= wb_final;
      end
   end

   `MSSC_ASSERT_IMPL(a_inflight_bound, clock, reset, 1'b1,
      inflight <= CNT_W'(OUT_DEPTH), "requests in flight exceed queue space")
   `MSSC_ASSERT_IMPL(a_clear_idle, clock, reset, clr_busy_ff,
      !ex_vld_ff && !wb_vld_ff && (cnt_ff == '0), "work in flight during clearing pass")
   `MSSC_ASSERT_NEXT(a_no_stall, clock, reset, ex_vld_ff, wb_vld_ff,
      "execute stage item lost before writeback")
   `MSSC_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff,
      "halted flag cleared without reset")
   `MSSC_ASSERT_NEXT(a_pc_hold, clock, reset,
      ex_vld_ff && (ex_res.status != STATUS_EXEC), $stable(pc_ff),
      "pc moved on halt, illegal or preload")

endmodule

`default_nettype wire
